// ----- rtl/core/mbmd_pkg.sv -----
package mbmd_pkg;

  // event kinds
  localparam logic [2:0] KIND_NOTE_ON    = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF   = 3'd1;
  localparam logic [2:0] KIND_VOLUME     = 3'd2;
  localparam logic [2:0] KIND_MODULATION = 3'd3;
  localparam logic [2:0] KIND_NOISE      = 3'd4;
  localparam logic [2:0] KIND_DETUNE     = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN_CC = 3'd6;

  // status nibbles
  localparam logic [3:0] TYPE_NOTE_OFF = 4'b1000;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'b1001;

  // controller numbers
  localparam logic [6:0] CC_MODULATION = 7'd1;
  localparam logic [6:0] CC_VOLUME     = 7'd7;
  localparam logic [6:0] CC_DETUNE     = 7'd71;
  localparam logic [6:0] CC_NOISE      = 7'd74;

  localparam logic [6:0] VOLUME_RESET = 7'd127;

  // finished message from the parser
  typedef struct packed {
    logic       done;
    logic [3:0] status_type;
    logic [6:0] first;
    logic [6:0] second;
  } msg_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [6:0] key_or_controller;
    logic [6:0] data_value;
    logic [6:0] volume_level;
    logic [6:0] modulation_level;
    logic [6:0] noise_level;
    logic [6:0] detune_level;
  } event_t;

  // note off, note on or control change on any channel
  function automatic logic is_wanted_status(input logic [7:0] b);
    return b inside {[8'h80:8'h9F], [8'hB0:8'hBF]};
  endfunction

endpackage

// ----- rtl/core/mbmd_if.sv -----
interface mbmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface mbmd_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [6:0] key_or_controller;
  logic [6:0] data_value;
  logic [6:0] volume_level;
  logic [6:0] modulation_level;
  logic [6:0] noise_level;
  logic [6:0] detune_level;

  modport source (
    output valid, output event_kind, output key_or_controller, output data_value,
    output volume_level, output modulation_level, output noise_level,
    output detune_level, input ready
  );
  modport sink (
    input valid, input event_kind, input key_or_controller, input data_value,
    input volume_level, input modulation_level, input noise_level,
    input detune_level, output ready
  );
endinterface

// ----- rtl/core/mbmd_parser.sv -----
module mbmd_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    byte_in,
  output mbmd_pkg::msg_t msg
);

  typedef enum logic [1:0] {
    WAIT_STATUS = 2'd0,
    GET_FIRST   = 2'd1,
    GET_SECOND  = 2'd2
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] status_r, status_nxt;
  logic [6:0] first_r, first_nxt;
  logic       done;

  always_comb begin
    state_nxt  = WAIT_STATUS;
    status_nxt = status_r;
    first_nxt  = first_r;
    done       = 1'b0;
    if ((state_r == GET_FIRST) && !byte_in[7]) begin
      first_nxt = byte_in[6:0];
      state_nxt = GET_SECOND;
    end else if ((state_r == GET_SECOND) && !byte_in[7]) begin
      done = step;
    end else if (mbmd_pkg::is_wanted_status(byte_in)) begin
      // status byte, also one that cuts a partial message short
      status_nxt = byte_in[7:4];
      state_nxt  = GET_FIRST;
    end
  end

  assign msg.done        = done;
  assign msg.status_type = status_r;
  assign msg.first       = first_r;
  assign msg.second      = byte_in[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= WAIT_STATUS;
      status_r <= '0;
      first_r  <= '0;
    end else if (step) begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

// ----- rtl/core/mbmd_levels.sv -----
module mbmd_levels (
  input  logic             clk,
  input  logic             rst_n,
  input  mbmd_pkg::msg_t   msg,
  output mbmd_pkg::event_t evt
);

  logic [6:0] volume_r, volume_nxt;
  logic [6:0] mod_r, mod_nxt;
  logic [6:0] noise_r, noise_nxt;
  logic [6:0] detune_r, detune_nxt;
  logic [2:0] kind;

  always_comb begin
    volume_nxt = volume_r;
    mod_nxt    = mod_r;
    noise_nxt  = noise_r;
    detune_nxt = detune_r;
    if (msg.status_type == mbmd_pkg::TYPE_NOTE_ON) begin
      kind = mbmd_pkg::KIND_NOTE_ON;
    end else if (msg.status_type == mbmd_pkg::TYPE_NOTE_OFF) begin
      kind = mbmd_pkg::KIND_NOTE_OFF;
    end else begin
      case (msg.first)
        mbmd_pkg::CC_VOLUME: begin
          kind       = mbmd_pkg::KIND_VOLUME;
          volume_nxt = msg.second;
        end
        mbmd_pkg::CC_MODULATION: begin
          kind    = mbmd_pkg::KIND_MODULATION;
          mod_nxt = msg.second;
        end
        mbmd_pkg::CC_NOISE: begin
          kind      = mbmd_pkg::KIND_NOISE;
          noise_nxt = msg.second;
        end
        mbmd_pkg::CC_DETUNE: begin
          kind       = mbmd_pkg::KIND_DETUNE;
          detune_nxt = msg.second;
        end
        default: begin
          kind = mbmd_pkg::KIND_UNKNOWN_CC;
        end
      endcase
    end
  end

  // levels shown are the ones after this message
  assign evt.event_kind        = kind;
  assign evt.key_or_controller = msg.first;
  assign evt.data_value        = msg.second;
  assign evt.volume_level      = volume_nxt;
  assign evt.modulation_level  = mod_nxt;
  assign evt.noise_level       = noise_nxt;
  assign evt.detune_level      = detune_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= mbmd_pkg::VOLUME_RESET;
      mod_r    <= '0;
      noise_r  <= '0;
      detune_r <= '0;
    end else if (msg.done) begin
      volume_r <= volume_nxt;
      mod_r    <= mod_nxt;
      noise_r  <= noise_nxt;
      detune_r <= detune_nxt;
    end
  end

endmodule

// ----- rtl/core/midi_byte_message_decoder.sv -----
// path: an item is registered at the input, then decoded into the result register;
//   an event is offered from the result register once the item that ends its message is decoded
// throughput: one byte item per cycle, set by the single decode step between the two
//   registers; a full result register only stalls the input when not being taken
// reset: synchronous active-low rst_n empties both registers, returns the parser to
//   waiting for status, sets volume to 127 and the other levels to zero
module midi_byte_message_decoder (
  input  logic                clk,
  input  logic                rst_n,
  mbmd_byte_if.sink           in_ch,
  mbmd_event_if.source        out_ch
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // result register
  logic             out_valid_r, out_valid_nxt;
  mbmd_pkg::event_t out_evt_r;

  // decode step
  logic             adv;
  mbmd_pkg::msg_t   msg;
  mbmd_pkg::event_t evt;

  // the byte moves on whenever the result register is free or being emptied
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;

  mbmd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .byte_in (in_byte_r),
    .msg     (msg)
  );

  // levels only change on a finished message, so done already carries adv
  mbmd_levels u_levels (
    .clk   (clk),
    .rst_n (rst_n),
    .msg   (msg),
    .evt   (evt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (msg.done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
    end
    if (msg.done) begin
      out_evt_r <= evt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.event_kind        = out_evt_r.event_kind;
  assign out_ch.key_or_controller = out_evt_r.key_or_controller;
  assign out_ch.data_value        = out_evt_r.data_value;
  assign out_ch.volume_level      = out_evt_r.volume_level;
  assign out_ch.modulation_level  = out_evt_r.modulation_level;
  assign out_ch.noise_level       = out_evt_r.noise_level;
  assign out_ch.detune_level      = out_evt_r.detune_level;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  // control change status nibble, not in the package
  localparam logic [3:0] TYPE_CONTROL = 4'b1011;

  // cycles with no item moving on either side before giving up
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // receiver hold-off, long enough to back up both stages and stall the input
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // settle time at the end, after the last owed event is in
  localparam int unsigned END_SETTLE = 8;

  typedef enum logic [1:0] {
    WAIT_STATUS,
    WAIT_FIRST,
    WAIT_SECOND
  } parse_pos_t;

  // tracks the parser and the stored levels, keeps the events still owed
  class midi_event_book;
    parse_pos_t        parse_pos;
    logic [7:0]        held_status;
    logic [6:0]        held_first;
    logic [6:0]        volume;
    logic [6:0]        modulation;
    logic [6:0]        noise;
    logic [6:0]        detune;
    mbmd_pkg::event_t  pending_events[$];
    int unsigned       mismatch_count;

    function new();
      parse_pos      = WAIT_STATUS;
      held_status    = '0;
      held_first     = '0;
      volume         = mbmd_pkg::VOLUME_RESET;
      modulation     = '0;
      noise          = '0;
      detune         = '0;
      mismatch_count = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      mbmd_pkg::event_t ev;
      if (parse_pos != WAIT_STATUS && !b[7]) begin
        if (parse_pos == WAIT_FIRST) begin
          held_first = b[6:0];
          parse_pos  = WAIT_SECOND;
          return;
        end
        parse_pos = WAIT_STATUS;
        if (held_status[7:4] == mbmd_pkg::TYPE_NOTE_ON) begin
          ev.event_kind = mbmd_pkg::KIND_NOTE_ON;
        end else if (held_status[7:4] == mbmd_pkg::TYPE_NOTE_OFF) begin
          ev.event_kind = mbmd_pkg::KIND_NOTE_OFF;
        end else begin
          case (held_first)
            mbmd_pkg::CC_VOLUME: begin
              volume        = b[6:0];
              ev.event_kind = mbmd_pkg::KIND_VOLUME;
            end
            mbmd_pkg::CC_MODULATION: begin
              modulation    = b[6:0];
              ev.event_kind = mbmd_pkg::KIND_MODULATION;
            end
            mbmd_pkg::CC_NOISE: begin
              noise         = b[6:0];
              ev.event_kind = mbmd_pkg::KIND_NOISE;
            end
            mbmd_pkg::CC_DETUNE: begin
              detune        = b[6:0];
              ev.event_kind = mbmd_pkg::KIND_DETUNE;
            end
            default: begin
              ev.event_kind = mbmd_pkg::KIND_UNKNOWN_CC;
            end
          endcase
        end
        ev.key_or_controller = held_first;
        ev.data_value        = b[6:0];
        ev.volume_level      = volume;
        ev.modulation_level  = modulation;
        ev.noise_level       = noise;
        ev.detune_level      = detune;
        pending_events.push_back(ev);
        return;
      end
      // waiting for status, or a status byte broke into a message
      parse_pos = WAIT_STATUS;
      if (b[7:4] == mbmd_pkg::TYPE_NOTE_OFF || b[7:4] == mbmd_pkg::TYPE_NOTE_ON ||
          b[7:4] == TYPE_CONTROL) begin
        held_status = b;
        parse_pos   = WAIT_FIRST;
      end
    endfunction

    function void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatch_count++;
      end
    endfunction

    function void match_event(mbmd_pkg::event_t got);
      mbmd_pkg::event_t want;
      if (pending_events.size() == 0) begin
        $error("event kind %0d arrived with none outstanding", got.event_kind);
        mismatch_count++;
        return;
      end
      want = pending_events.pop_front();
      check_field("event_kind", want.event_kind, got.event_kind);
      check_field("key_or_controller", want.key_or_controller, got.key_or_controller);
      check_field("data_value", want.data_value, got.data_value);
      check_field("volume_level", want.volume_level, got.volume_level);
      check_field("modulation_level", want.modulation_level, got.modulation_level);
      check_field("noise_level", want.noise_level, got.noise_level);
      check_field("detune_level", want.detune_level, got.detune_level);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mbmd_byte_if  byte_ch ();
  mbmd_event_if event_ch ();

  midi_byte_message_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (event_ch)
  );

  midi_event_book book;
  logic [7:0]     byte_stream[$];
  bit             hold_off_req;
  int unsigned    idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender side: drive at the falling edge, see the handshake at the rising edge
  task automatic send_byte(logic [7:0] b);
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    book.take_byte(b);
    @(negedge clk);
  endtask

  task automatic pause_sender(int unsigned n_cycles);
    byte_ch.valid   <= 1'b0;
    byte_ch.in_byte <= 8'($urandom);
    repeat (n_cycles) @(negedge clk);
  endtask

  // bursts of random length, gaps between most of them
  task automatic drive_stream();
    int unsigned burst_left;
    burst_left = 0;
    while (byte_stream.size() > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          pause_sender($urandom_range(1, 8));
        end
      end
      send_byte(byte_stream.pop_front());
      burst_left--;
    end
    byte_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_for_events();
    while (book.pending_events.size() != 0) @(negedge clk);
  endtask

  // mostly whole messages with random content, the rest noise and cut-off messages
  function automatic void queue_traffic(int unsigned n_bytes);
    logic [7:0]  status;
    logic [6:0]  first;
    int unsigned pick;
    while (byte_stream.size() < n_bytes) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0:       status = {mbmd_pkg::TYPE_NOTE_ON, 4'($urandom)};
        1:       status = {mbmd_pkg::TYPE_NOTE_OFF, 4'($urandom)};
        default: status = {TYPE_CONTROL, 4'($urandom)};
      endcase
      // control changes lean toward the controllers that store a level
      first = 7'($urandom_range(0, 127));
      if (status[7:4] == TYPE_CONTROL && $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 3))
          0:       first = mbmd_pkg::CC_VOLUME;
          1:       first = mbmd_pkg::CC_MODULATION;
          2:       first = mbmd_pkg::CC_NOISE;
          default: first = mbmd_pkg::CC_DETUNE;
        endcase
      end
      if (pick < 78) begin
        byte_stream.push_back(status);
        byte_stream.push_back({1'b0, first});
        byte_stream.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 86) begin
        byte_stream.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        // status byte where the first data byte belongs
        byte_stream.push_back(status);
        byte_stream.push_back(8'($urandom_range(128, 255)));
      end else begin
        // status byte where the second data byte belongs
        byte_stream.push_back(status);
        byte_stream.push_back({1'b0, first});
        byte_stream.push_back(8'($urandom_range(128, 255)));
      end
    end
  endfunction

  // receiver: shifting stall patterns, plus one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    event_ch.ready = 1'b0;
    mode_left      = 0;
    tick           = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        event_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      tick++;
      case (mode)
        0:       event_ch.ready <= 1'b1;
        1:       event_ch.ready <= ($urandom_range(0, 3) != 0);
        default: event_ch.ready <= ((tick % 5) < 2);
      endcase
    end
  end

  // result check and watchdog, both on the rising edge
  always @(posedge clk) begin
    if (rst_n && event_ch.valid && event_ch.ready) begin
      book.match_event('{event_ch.event_kind, event_ch.key_or_controller,
                         event_ch.data_value, event_ch.volume_level,
                         event_ch.modulation_level, event_ch.noise_level,
                         event_ch.detune_level});
    end
    if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    book            = new();
    idle_cycles     = 0;
    hold_off_req    = 1'b0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    rst_n           = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    byte_stream = '{
      8'hFF, 8'hE3,                     // unwanted bytes while waiting, pitch bend among them
      8'h90, 8'h00, 8'h00,              // note on, key 0, velocity zero
      8'h8F, 8'h7F, 8'h7F,              // note off, channel 15, top key and velocity
      8'h9A, 8'h3C, 8'hB0, 8'h07, 8'h00, // control change cuts in on a note, volume to 0
      8'hB5, 8'h01, 8'h7F,              // modulation
      8'hBA, 8'h4A, 8'h40,              // noise
      8'hBF, 8'h47, 8'h01,              // detune
      8'hB3, 8'h7F, 8'h37,              // unknown controller
      8'h85, 8'hA5,                     // unwanted status where first data belongs
      8'h2A                             // data byte while waiting
    };
    drive_stream();
    wait_for_events();

    // random part; the sender waits for everything owed after the first chunk
    queue_traffic(225);
    drive_stream();
    wait_for_events();

    // receiver goes quiet while the sender keeps pushing
    queue_traffic(225);
    hold_off_req = 1'b1;
    drive_stream();

    queue_traffic(225);
    drive_stream();

    wait_for_events();
    repeat (END_SETTLE) @(negedge clk);
    if (book.mismatch_count == 0 && book.pending_events.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mbmd_pkg.sv
rtl/core/mbmd_if.sv
rtl/core/mbmd_parser.sv
rtl/core/mbmd_levels.sv
rtl/core/midi_byte_message_decoder.sv
tb/tb.sv
